// ===== rtl/i2c_command_read_sequencer_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef I2C_COMMAND_READ_SEQUENCER_DEFINES_SVH
`define I2C_COMMAND_READ_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, skipped while reset is high.
`define ICRS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("icrs assertion failed");

// Check a property on every rising edge, reset included.
`define ICRS_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("icrs assertion failed");

`else

`define ICRS_ASSERT(lbl, clk_s, rst_s, prop)
`define ICRS_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

// ===== rtl/icrs_pkg.sv =====
package icrs_pkg;

  localparam int MAX_READ_LEN = 16;

  localparam int LEN_W   = 5;
  localparam int INDEX_W = 4;

  localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_READ_LEN);

  // Request kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // Address byte read/write bit
  localparam logic RW_READ_BIT  = 1'b1;
  localparam logic RW_WRITE_BIT = 1'b0;

  // Engine actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_ADDR = 3'd1;
  localparam logic [2:0] ACT_DATA = 3'd2;
  localparam logic [2:0] ACT_STOP = 3'd3;
  localparam logic [2:0] ACT_NEXT = 3'd4;

  // Completion status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_NACK  = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_CMD  = 2'd2,
    PH_READ = 2'd3
  } phase_t;

  typedef struct packed {
    logic             command;
    logic [6:0]       slave_address;
    logic [7:0]       command_byte;
    logic [LEN_W-1:0] read_length;
    logic             bus_fault;
    logic             nack_seen;
    logic             write_flag;
    logic [7:0]       rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         action_byte;
    logic               read_valid;
    logic [7:0]         read_byte;
    logic [INDEX_W-1:0] read_index;
    logic               done_res;
    logic [1:0]         status;
    logic               refused;
  } res_t;

endpackage

// ===== rtl/icrs_core.sv =====
`include "i2c_command_read_sequencer_defines.svh"

module icrs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  icrs_pkg::req_t    req_data,
  output icrs_pkg::res_t    res_data
);

  icrs_pkg::phase_t               phase;
  icrs_pkg::phase_t               phase_next;
  logic [icrs_pkg::LEN_W-1:0]     bytes_read;
  logic [icrs_pkg::LEN_W-1:0]     bytes_read_next;
  logic [icrs_pkg::LEN_W-1:0]     bytes_inc;
  logic [6:0]                     held_address;
  logic [7:0]                     held_command;
  logic [icrs_pkg::LEN_W-1:0]     held_length;
  logic [icrs_pkg::LEN_W-1:0]     len_sat;
  logic                           latch;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= icrs_pkg::PH_IDLE;
      bytes_read <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_read <= bytes_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && latch) begin
      held_address <= req_data.slave_address;
      held_command <= req_data.command_byte;
      held_length  <= len_sat;
    end
  end

  assign len_sat   = (req_data.read_length > icrs_pkg::MAX_LEN_V) ? icrs_pkg::MAX_LEN_V
                                                                  : req_data.read_length;
  assign bytes_inc = bytes_read + icrs_pkg::LEN_W'(1);

  always_comb begin
    res_data        = '0;
    phase_next      = phase;
    bytes_read_next = bytes_read;
    latch           = 1'b0;
    if (req_data.command == icrs_pkg::CMD_START) begin
      if (phase != icrs_pkg::PH_IDLE) begin
        res_data.status  = icrs_pkg::ST_BUSY;
        res_data.refused = 1'b1;
      end else begin
        latch                = 1'b1;
        bytes_read_next      = '0;
        phase_next           = icrs_pkg::PH_ADDR;
        res_data.action      = icrs_pkg::ACT_ADDR;
        res_data.action_byte = {req_data.slave_address, icrs_pkg::RW_WRITE_BIT};
      end
    end else begin
      case (phase)
        icrs_pkg::PH_ADDR: begin
          if (req_data.bus_fault) begin
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_FAULT;
            phase_next        = icrs_pkg::PH_IDLE;
          end else if (req_data.nack_seen) begin
            res_data.action   = icrs_pkg::ACT_STOP;
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_NACK;
            phase_next        = icrs_pkg::PH_IDLE;
          end else begin
            res_data.action      = icrs_pkg::ACT_DATA;
            res_data.action_byte = held_command;
            phase_next           = icrs_pkg::PH_CMD;
          end
        end
        icrs_pkg::PH_CMD: begin
          if (req_data.bus_fault) begin
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_FAULT;
            phase_next        = icrs_pkg::PH_IDLE;
          end else if (req_data.nack_seen) begin
            res_data.action   = icrs_pkg::ACT_STOP;
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_NACK;
            phase_next        = icrs_pkg::PH_IDLE;
          end else if (held_length == '0) begin
            res_data.action   = icrs_pkg::ACT_STOP;
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_OK;
            phase_next        = icrs_pkg::PH_IDLE;
          end else begin
            res_data.action      = icrs_pkg::ACT_ADDR;
            res_data.action_byte = {held_address, icrs_pkg::RW_READ_BIT};
            phase_next           = icrs_pkg::PH_READ;
          end
        end
        icrs_pkg::PH_READ: begin
          if (req_data.bus_fault) begin
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_FAULT;
            phase_next        = icrs_pkg::PH_IDLE;
          end else if (req_data.nack_seen && req_data.write_flag) begin
            res_data.action   = icrs_pkg::ACT_STOP;
            res_data.done_res = 1'b1;
            res_data.status   = icrs_pkg::ST_NACK;
            phase_next        = icrs_pkg::PH_IDLE;
          end else begin
            res_data.read_valid = 1'b1;
            res_data.read_byte  = req_data.rx_byte;
            res_data.read_index = bytes_read[icrs_pkg::INDEX_W-1:0];
            bytes_read_next     = bytes_inc;
            if (bytes_inc >= held_length) begin
              res_data.action   = icrs_pkg::ACT_STOP;
              res_data.done_res = 1'b1;
              res_data.status   = icrs_pkg::ST_OK;
              phase_next        = icrs_pkg::PH_IDLE;
            end else begin
              res_data.action = icrs_pkg::ACT_NEXT;
            end
          end
        end
        default: begin
          res_data = '0;
        end
      endcase
    end
  end

  // A refused start leaves the transaction untouched
  `ICRS_ASSERT(a_refuse_keeps_phase, clk, rst,
    (accept && req_data.command == icrs_pkg::CMD_START && phase != icrs_pkg::PH_IDLE)
      |=> (phase == $past(phase) && bytes_read == $past(bytes_read)))
  // An accepted start from idle lands in the address phase with a fresh count
  `ICRS_ASSERT(a_start_enters_addr, clk, rst,
    (accept && req_data.command == icrs_pkg::CMD_START && phase == icrs_pkg::PH_IDLE)
      |=> (phase == icrs_pkg::PH_ADDR && bytes_read == '0))
  // While reading, the count stays below the latched length
  `ICRS_ASSERT(a_count_below_len, clk, rst,
    (phase == icrs_pkg::PH_READ) |-> (bytes_read < held_length))

endmodule

// ===== rtl/icrs_out_buf.sv =====
`include "i2c_command_read_sequencer_defines.svh"

module icrs_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  icrs_pkg::res_t    push_data,
  output logic              space,
  output logic              res_valid,
  input  logic              res_ready,
  output icrs_pkg::res_t    res_data
);

  icrs_pkg::res_t slot0;
  icrs_pkg::res_t slot1;
  logic [1:0]     count;
  logic           pop;

  assign pop       = res_valid && res_ready;
  assign space     = (count != 2'd2);
  assign res_valid = (count != 2'd0);
  assign res_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= push_data;
        end else begin
          slot1 <= push_data;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_data;
        end else begin
          slot0 <= slot1;
          slot1 <= push_data;
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

  `ICRS_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (count == 2'd0))
  `ICRS_ASSERT(a_count_in_range, clk, rst, (count != 2'd3))
  `ICRS_ASSERT(a_push_grows, clk, rst,
    (push && !pop) |=> (count == $past(count) + 2'd1))
  `ICRS_ASSERT(a_no_push_when_full, clk, rst, (count == 2'd2) |-> !push)

endmodule

// ===== rtl/i2c_command_read_sequencer.sv =====
// I2C command-then-read sequencer. Each request is either a start (command 0:
// slave address, command byte, read length) or an engine event (command 1:
// fault, NACK and write flags plus the received byte), and every accepted
// request yields exactly one result telling the engine what to do next
// (address byte, data byte, ACK-next or NACK-and-stop), delivering any read
// byte with its index, and flagging completion or a busy refusal with a
// status code. A request is taken every cycle while the two-entry result
// buffer has room; its result is registered into that buffer on acceptance.
// Throughput is one request per clock while the result buffer has room; the
// phase register updates once per accepted request. Read lengths above
// MAX_READ_LEN are clipped to it. Events arriving while idle yield an
// all-zero result.

module i2c_command_read_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  icrs_pkg::req_t    req_data,
  output logic              res_valid,
  input  logic              res_ready,
  output icrs_pkg::res_t    res_data
);

  logic           accept;
  logic           space;
  icrs_pkg::res_t step_res;

  // Take a request whenever the result buffer can hold its result.
  assign req_ready = space;
  assign accept    = req_valid && req_ready;

  // Phase register, byte counter and latched transaction fields; the next
  // phase and the result come from short logic on the request.
  icrs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_data (req_data),
    .res_data (step_res)
  );

  // Hold results until the consumer takes them; two entries keep requests
  // flowing while one result waits.
  icrs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

// ===== sim/sequencer_action_checker.sv =====
module sequencer_action_checker
  import icrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res_data,
  output int   mismatches,
  output int   outstanding
);

  // Shadow of the transaction state
  phase_t           seq_phase;
  logic [4:0]       rx_count;
  logic [6:0]       held_addr;
  logic [7:0]       held_cmd;
  logic [LEN_W-1:0] held_len;

  res_t expected_actions[$];
  res_t oldest;
  int   error_total = 0;

  function automatic res_t predict_action(input req_t r);
    res_t       o;
    logic       ends;
    logic [1:0] end_status;
    o          = '0;
    ends       = 1'b0;
    end_status = ST_OK;
    if (r.command == CMD_START) begin
      if (seq_phase != PH_IDLE) begin
        o.status  = ST_BUSY;
        o.refused = 1'b1;
      end else begin
        held_addr     = r.slave_address;
        held_cmd      = r.command_byte;
        held_len      = (r.read_length > MAX_LEN_V) ? MAX_LEN_V : r.read_length;
        rx_count      = '0;
        seq_phase     = PH_ADDR;
        o.action      = ACT_ADDR;
        o.action_byte = {r.slave_address, RW_WRITE_BIT};
      end
    end else begin
      case (seq_phase)
        PH_ADDR, PH_CMD: begin
          if (r.bus_fault) begin
            ends       = 1'b1;
            end_status = ST_FAULT;
          end else if (r.nack_seen) begin
            o.action   = ACT_STOP;
            ends       = 1'b1;
            end_status = ST_NACK;
          end else if (seq_phase == PH_ADDR) begin
            o.action      = ACT_DATA;
            o.action_byte = held_cmd;
            seq_phase     = PH_CMD;
          end else if (held_len == '0) begin
            o.action   = ACT_STOP;
            ends       = 1'b1;
            end_status = ST_OK;
          end else begin
            o.action      = ACT_ADDR;
            o.action_byte = {held_addr, RW_READ_BIT};
            seq_phase     = PH_READ;
          end
        end
        PH_READ: begin
          if (r.bus_fault) begin
            ends       = 1'b1;
            end_status = ST_FAULT;
          end else if (r.nack_seen && r.write_flag) begin
            o.action   = ACT_STOP;
            ends       = 1'b1;
            end_status = ST_NACK;
          end else begin
            o.read_valid = 1'b1;
            o.read_byte  = r.rx_byte;
            o.read_index = rx_count[INDEX_W-1:0];
            rx_count     = rx_count + 5'd1;
            if (rx_count >= held_len) begin
              o.action   = ACT_STOP;
              ends       = 1'b1;
              end_status = ST_OK;
            end else begin
              o.action = ACT_NEXT;
            end
          end
        end
        default: ;
      endcase
    end
    if (ends) begin
      o.done_res = 1'b1;
      o.status   = end_status;
      seq_phase  = PH_IDLE;
    end
    return o;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_phase = PH_IDLE;
      rx_count  = '0;
      held_addr = '0;
      held_cmd  = '0;
      held_len  = '0;
      expected_actions.delete();
    end else begin
      // Retire the result first: a request taken at this edge cannot answer yet
      if (res_valid && res_ready) begin
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, res_data);
          error_total++;
        end else begin
          oldest = expected_actions.pop_front();
          check_field("action",      32'(oldest.action),      32'(res_data.action));
          check_field("action_byte", 32'(oldest.action_byte), 32'(res_data.action_byte));
          check_field("read_valid",  32'(oldest.read_valid),  32'(res_data.read_valid));
          check_field("read_byte",   32'(oldest.read_byte),   32'(res_data.read_byte));
          check_field("read_index",  32'(oldest.read_index),  32'(res_data.read_index));
          check_field("done_res",    32'(oldest.done_res),    32'(res_data.done_res));
          check_field("status",      32'(oldest.status),      32'(res_data.status));
          check_field("refused",     32'(oldest.refused),     32'(res_data.refused));
        end
      end
      if (req_valid && req_ready)
        expected_actions.push_back(predict_action(req_data));
    end
    mismatches  <= error_total;
    outstanding <= expected_actions.size();
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import icrs_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_PCT     = 35;
  localparam int HOLD_CYCLES  = 80;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic res_valid;
  logic res_ready;
  res_t res_data;

  int mismatch_count;
  int pending_actions;

  // Random gap rates for both sides; the sink rate is read by the sink process
  int src_idle_pct = IDLE_PCT;
  int snk_idle_pct = IDLE_PCT;
  // One-shot request for the long sink hold-off
  logic hold_off_req = 1'b0;

  always #10 clk = ~clk;

  i2c_command_read_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  sequencer_action_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mismatches  (mismatch_count),
    .outstanding (pending_actions)
  );

  // Hard stop in case the block hangs or a result never shows up
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result sink: random back-pressure, plus one long hold-off when asked
  initial begin : sink
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // Hold ready low so the result buffer fills and stalls the requests
        res_ready <= 1'b0;
        hold_left--;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Offer one request, with random gaps ahead of it; return at the edge that takes it
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Start request; the event fields ride along with random content
  task automatic send_start(input logic [6:0] addr, input logic [7:0] cmd,
                            input logic [LEN_W-1:0] len);
    req_t r;
    r               = req_t'($urandom);
    r.command       = CMD_START;
    r.slave_address = addr;
    r.command_byte  = cmd;
    r.read_length   = len;
    send_request(r);
  endtask

  // Engine event; the start fields ride along with random content
  task automatic send_event(input logic fault, input logic nack, input logic wif,
                            input logic [7:0] rx);
    req_t r;
    r            = req_t'($urandom);
    r.command    = CMD_EVENT;
    r.bus_fault  = fault;
    r.nack_seen  = nack;
    r.write_flag = wif;
    r.rx_byte    = rx;
    send_request(r);
  endtask

  // Drop valid beforehand; the outstanding count is registered in the checker, so step once first
  task automatic wait_drained();
    @(posedge clk);
    while (pending_actions != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int               items_done;
    int               step;
    int               last_step;
    int               pick;
    int               eff_len;
    logic [6:0]       addr;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
    logic             fault;
    logic             nack;
    logic             quiet_started;
    logic             quiet_ended;
    logic             pause_done;

    items_done    = 0;
    quiet_started = 1'b0;
    quiet_ended   = 1'b0;
    pause_done    = 1'b0;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    // Event with nothing active: all-zero answer
    send_event(1'b1, 1'b1, 1'b1, 8'hFF);
    // Write-only transaction at the top address and command byte
    send_start(7'h7F, 8'hFF, 5'd0);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    // One-byte read; a start while busy is refused; NACK without write flag is data
    send_start(7'h00, 8'h00, 5'd1);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 1'b1, 8'h00);
    send_start(7'h55, 8'hAA, 5'd31);
    send_event(1'b0, 1'b1, 1'b0, 8'hFF);
    // Bus fault together with NACK on the address: fault wins
    send_start(7'h2A, 8'h5A, 5'd2);
    send_event(1'b1, 1'b1, 1'b1, 8'h3C);
    // NACK on the address byte
    send_start(7'h15, 8'hC3, 5'd4);
    send_event(1'b0, 1'b1, 1'b0, 8'h81);
    // NACK on the command byte
    send_start(7'h40, 8'h01, 5'd3);
    send_event(1'b0, 1'b0, 1'b1, 8'h7E);
    send_event(1'b0, 1'b1, 1'b1, 8'h18);
    // NACK with write flag while reading
    send_start(7'h3F, 8'h80, 5'd2);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 1'b0, 8'hA5);
    send_event(1'b0, 1'b1, 1'b1, 8'h5A);
    // Bus fault while reading
    send_start(7'h01, 8'h7F, 5'd16);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);
    send_event(1'b1, 1'b0, 1'b0, 8'hFF);

    // Pause the sender until every directed answer is back
    req_valid <= 1'b0;
    wait_drained();

    // Random part: mostly well-formed transactions with injected faults and noise
    while (items_done < RANDOM_ITEMS) begin
      // Run a stretch with no gaps on either side
      if (!quiet_started && items_done >= 150) begin
        quiet_started = 1'b1;
        src_idle_pct  = 0;
        snk_idle_pct <= 0;
      end
      if (!quiet_ended && items_done >= 250) begin
        quiet_ended   = 1'b1;
        src_idle_pct  = IDLE_PCT;
        snk_idle_pct <= IDLE_PCT;
      end
      // Ask the sink for its long hold-off while requests keep coming
      if (items_done >= 300)
        hold_off_req <= 1'b1;
      // Pause the sender again until the block has answered everything
      if (!pause_done && items_done >= 420) begin
        pause_done = 1'b1;
        req_valid <= 1'b0;
        wait_drained();
      end

      // Noise between transactions: an event with nothing active
      if ($urandom_range(0, 99) < 8)
        send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

      addr = 7'($urandom_range(0, 127));
      cmd  = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = LEN_W'($urandom_range(0, 4));
      else if (pick < 90) len = LEN_W'($urandom_range(5, 16));
      else                len = LEN_W'($urandom_range(17, 31));
      eff_len   = (len > MAX_LEN_V) ? MAX_READ_LEN : int'(len);
      last_step = (eff_len == 0) ? 1 : eff_len + 1;

      send_start(addr, cmd, len);
      items_done++;

      // Step 0 answers the address, step 1 the command byte, then the read bytes
      for (step = 0; step <= last_step; step++) begin
        if ($urandom_range(0, 99) < 5) begin
          send_start(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, 31)));
          items_done++;
        end
        fault = 1'b0;
        nack  = 1'b0;
        pick  = $urandom_range(0, 99);
        if (pick < 3) begin
          fault = 1'b1;
          nack  = 1'($urandom_range(0, 1));
        end else if (pick < 8) begin
          nack = 1'b1;
        end
        pick = $urandom_range(0, 1);
        send_event(fault, nack, pick[0], 8'($urandom_range(0, 255)));
        items_done++;
        // Drop the rest of the transaction once it has ended early
        if (fault || (nack && (step < 2 || pick[0])))
          break;
      end
    end

    // Drain, then give any stray result time to show up
    req_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_actions == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/icrs_pkg.sv
rtl/icrs_core.sv
rtl/icrs_out_buf.sv
rtl/i2c_command_read_sequencer.sv
sim/sequencer_action_checker.sv
sim/testbench.sv
